@@ hdl/cpu8alu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8alu_pkg
// Operation codes and shared types for the 8-bit processor ALU with flags.
// ----------------------------------------------------------------------------
package cpu8alu_pkg;

  // Operation codes carried on the command field.
  typedef enum logic [4:0] {
    CMD_ADD    = 5'd0,
    CMD_ADC    = 5'd1,
    CMD_SUB    = 5'd2,
    CMD_SBC    = 5'd3,
    CMD_AND    = 5'd4,
    CMD_XOR    = 5'd5,
    CMD_OR     = 5'd6,
    CMD_CP     = 5'd7,
    CMD_INC    = 5'd8,
    CMD_DEC    = 5'd9,
    CMD_RLC    = 5'd10,
    CMD_RRC    = 5'd11,
    CMD_RL     = 5'd12,
    CMD_RR     = 5'd13,
    CMD_SLA    = 5'd14,
    CMD_SRA    = 5'd15,
    CMD_SWAP   = 5'd16,
    CMD_SRL    = 5'd17,
    CMD_BIT    = 5'd18,
    CMD_RES    = 5'd19,
    CMD_SET    = 5'd20,
    CMD_DAA    = 5'd21,
    CMD_CPL    = 5'd22,
    CMD_CCF    = 5'd23,
    CMD_SCF    = 5'd24,
    CMD_ADD16  = 5'd25,
    CMD_ADD_SP = 5'd26,
    CMD_RLCA   = 5'd27,
    CMD_RLA    = 5'd28,
    CMD_RRCA   = 5'd29,
    CMD_RRA    = 5'd30
  } cmd_t;

  // Processor flag set.
  typedef struct packed {
    logic zero;
    logic subtract;
    logic half_carry;
    logic carry;
  } flags_t;

  // One operation as seen by the ALU core.
  typedef struct packed {
    logic [4:0]  command;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    flags_t      flags;
  } alu_req_t;

  // One result item from the ALU core.
  typedef struct packed {
    logic [15:0] result;
    flags_t      flags;
  } alu_rsp_t;

  // Decimal adjust thresholds and corrections.
  localparam logic [7:0] DAA_HIGH_LIMIT = 8'h99;
  localparam logic [3:0] DAA_LOW_LIMIT  = 4'h9;
  localparam logic [7:0] DAA_HIGH_CORR  = 8'h60;
  localparam logic [7:0] DAA_LOW_CORR   = 8'h06;

endpackage

@@ hdl/cpu8alu_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8alu_core
// Combinational datapath: computes the result and new flags of one operation.
// ----------------------------------------------------------------------------
module cpu8alu_core (
  input  cpu8alu_pkg::alu_req_t req,
  output cpu8alu_pkg::alu_rsp_t rsp
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        use_cin;
  logic [8:0]  add_sum;
  logic [4:0]  add_nib;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_nib;
  logic [7:0]  add_b;
  logic [7:0]  bit_mask;
  logic [7:0]  daa_corr;
  logic        daa_carry;
  logic [7:0]  daa_value;
  logic [16:0] sum16;
  logic [12:0] sum12;
  logic [15:0] sp_ext;
  logic [8:0]  sp_byte;
  logic [4:0]  sp_nib;

  assign a   = req.operand_a[7:0];
  assign b   = req.operand_b[7:0];
  assign cin = req.flags.carry;

  // Shared 8-bit adder and subtractor; inc and dec use a constant one.
  always_comb begin
    use_cin = (req.command == cpu8alu_pkg::CMD_ADC) || (req.command == cpu8alu_pkg::CMD_SBC);
    add_b   = ((req.command == cpu8alu_pkg::CMD_INC) || (req.command == cpu8alu_pkg::CMD_DEC))
              ? 8'd1 : b;
    add_sum  = {1'b0, a} + {1'b0, add_b} + {8'd0, use_cin & cin};
    add_nib  = {1'b0, a[3:0]} + {1'b0, add_b[3:0]} + {4'd0, use_cin & cin};
    sub_diff = {1'b0, a} - {1'b0, add_b} - {8'd0, use_cin & cin};
    sub_nib  = {1'b0, a[3:0]} - {1'b0, add_b[3:0]} - {4'd0, use_cin & cin};
  end

  // Decimal adjust correction, taken from the incoming accumulator and flags.
  always_comb begin
    daa_corr  = 8'd0;
    daa_carry = req.flags.carry;
    if (!req.flags.subtract) begin
      if (req.flags.carry || (a > cpu8alu_pkg::DAA_HIGH_LIMIT)) begin
        daa_corr  = daa_corr | cpu8alu_pkg::DAA_HIGH_CORR;
        daa_carry = 1'b1;
      end
      if (req.flags.half_carry || (a[3:0] > cpu8alu_pkg::DAA_LOW_LIMIT)) begin
        daa_corr = daa_corr | cpu8alu_pkg::DAA_LOW_CORR;
      end
      daa_value = a + daa_corr;
    end else begin
      if (req.flags.carry) begin
        daa_corr = daa_corr | cpu8alu_pkg::DAA_HIGH_CORR;
      end
      if (req.flags.half_carry) begin
        daa_corr = daa_corr | cpu8alu_pkg::DAA_LOW_CORR;
      end
      daa_value = a - daa_corr;
    end
  end

  // 16-bit pair add and stack-pointer offset add.
  assign sum16   = {1'b0, req.operand_a} + {1'b0, req.operand_b};
  assign sum12   = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
  assign sp_ext  = {{8{b[7]}}, b};
  assign sp_byte = {1'b0, req.operand_a[7:0]} + {1'b0, b};
  assign sp_nib  = {1'b0, req.operand_a[3:0]} + {1'b0, b[3:0]};

  assign bit_mask = 8'd1 << req.bit_index;

  // Operation select; flags pass through unless an operation changes them.
  always_comb begin
    rsp.result = {8'd0, a};
    rsp.flags  = req.flags;
    unique case (req.command) inside
      cpu8alu_pkg::CMD_ADD, cpu8alu_pkg::CMD_ADC, cpu8alu_pkg::CMD_INC: begin
        rsp.result              = {8'd0, add_sum[7:0]};
        rsp.flags.zero          = (add_sum[7:0] == 8'd0);
        rsp.flags.subtract      = 1'b0;
        rsp.flags.half_carry    = add_nib[4];
        if (req.command != cpu8alu_pkg::CMD_INC) begin
          rsp.flags.carry = add_sum[8];
        end
      end
      cpu8alu_pkg::CMD_SUB, cpu8alu_pkg::CMD_SBC, cpu8alu_pkg::CMD_CP,
      cpu8alu_pkg::CMD_DEC: begin
        // Compare keeps the accumulator unchanged.
        if (req.command != cpu8alu_pkg::CMD_CP) begin
          rsp.result = {8'd0, sub_diff[7:0]};
        end
        rsp.flags.zero       = (sub_diff[7:0] == 8'd0);
        rsp.flags.subtract   = 1'b1;
        rsp.flags.half_carry = sub_nib[4];
        if (req.command != cpu8alu_pkg::CMD_DEC) begin
          rsp.flags.carry = sub_diff[8];
        end
      end
      cpu8alu_pkg::CMD_AND: begin
        rsp.result = {8'd0, a & b};
        rsp.flags  = '{zero: ((a & b) == 8'd0), subtract: 1'b0, half_carry: 1'b1, carry: 1'b0};
      end
      cpu8alu_pkg::CMD_XOR: begin
        rsp.result = {8'd0, a ^ b};
        rsp.flags  = '{zero: ((a ^ b) == 8'd0), subtract: 1'b0, half_carry: 1'b0, carry: 1'b0};
      end
      cpu8alu_pkg::CMD_OR: begin
        rsp.result = {8'd0, a | b};
        rsp.flags  = '{zero: ((a | b) == 8'd0), subtract: 1'b0, half_carry: 1'b0, carry: 1'b0};
      end
      cpu8alu_pkg::CMD_SWAP: begin
        rsp.result = {8'd0, a[3:0], a[7:4]};
        rsp.flags  = '{zero: (a == 8'd0), subtract: 1'b0, half_carry: 1'b0, carry: 1'b0};
      end
      cpu8alu_pkg::CMD_RLC, cpu8alu_pkg::CMD_RLCA: begin
        rsp.result = {8'd0, a[6:0], a[7]};
        rsp.flags  = '{zero: (a == 8'd0), subtract: 1'b0, half_carry: 1'b0, carry: a[7]};
      end
      cpu8alu_pkg::CMD_RRC, cpu8alu_pkg::CMD_RRCA: begin
        rsp.result = {8'd0, a[0], a[7:1]};
        rsp.flags  = '{zero: (a == 8'd0), subtract: 1'b0, half_carry: 1'b0, carry: a[0]};
      end
      cpu8alu_pkg::CMD_RL, cpu8alu_pkg::CMD_RLA: begin
        rsp.result = {8'd0, a[6:0], cin};
        rsp.flags  = '{zero: ({a[6:0], cin} == 8'd0), subtract: 1'b0, half_carry: 1'b0,
                       carry: a[7]};
      end
      cpu8alu_pkg::CMD_RR, cpu8alu_pkg::CMD_RRA: begin
        rsp.result = {8'd0, cin, a[7:1]};
        rsp.flags  = '{zero: ({cin, a[7:1]} == 8'd0), subtract: 1'b0, half_carry: 1'b0,
                       carry: a[0]};
      end
      cpu8alu_pkg::CMD_SLA: begin
        rsp.result = {8'd0, a[6:0], 1'b0};
        rsp.flags  = '{zero: (a[6:0] == 7'd0), subtract: 1'b0, half_carry: 1'b0, carry: a[7]};
      end
      cpu8alu_pkg::CMD_SRA: begin
        rsp.result = {8'd0, a[7], a[7:1]};
        rsp.flags  = '{zero: (a[7:1] == 7'd0), subtract: 1'b0, half_carry: 1'b0, carry: a[0]};
      end
      cpu8alu_pkg::CMD_SRL: begin
        rsp.result = {8'd0, 1'b0, a[7:1]};
        rsp.flags  = '{zero: (a[7:1] == 7'd0), subtract: 1'b0, half_carry: 1'b0, carry: a[0]};
      end
      cpu8alu_pkg::CMD_BIT: begin
        rsp.flags.zero       = ((a & bit_mask) == 8'd0);
        rsp.flags.subtract   = 1'b0;
        rsp.flags.half_carry = 1'b1;
      end
      cpu8alu_pkg::CMD_RES: begin
        rsp.result = {8'd0, a & ~bit_mask};
      end
      cpu8alu_pkg::CMD_SET: begin
        rsp.result = {8'd0, a | bit_mask};
      end
      cpu8alu_pkg::CMD_DAA: begin
        rsp.result           = {8'd0, daa_value};
        rsp.flags.zero       = (daa_value == 8'd0);
        rsp.flags.half_carry = 1'b0;
        rsp.flags.carry      = daa_carry;
      end
      cpu8alu_pkg::CMD_CPL: begin
        rsp.result           = {8'd0, ~a};
        rsp.flags.subtract   = 1'b1;
        rsp.flags.half_carry = 1'b1;
      end
      cpu8alu_pkg::CMD_CCF: begin
        rsp.flags.subtract   = 1'b0;
        rsp.flags.half_carry = 1'b0;
        rsp.flags.carry      = ~req.flags.carry;
      end
      cpu8alu_pkg::CMD_SCF: begin
        rsp.flags.subtract   = 1'b0;
        rsp.flags.half_carry = 1'b0;
        rsp.flags.carry      = 1'b1;
      end
      cpu8alu_pkg::CMD_ADD16: begin
        rsp.result           = sum16[15:0];
        rsp.flags.subtract   = 1'b0;
        rsp.flags.half_carry = sum12[12];
        rsp.flags.carry      = sum16[16];
      end
      cpu8alu_pkg::CMD_ADD_SP: begin
        rsp.result = req.operand_a + sp_ext;
        rsp.flags  = '{zero: 1'b0, subtract: 1'b0, half_carry: sp_nib[4], carry: sp_byte[8]};
      end
      default: begin
        // Unused code: zero result, flags unchanged.
        rsp.result = 16'd0;
      end
    endcase

    // Accumulator rotates always clear zero.
    if ((req.command == cpu8alu_pkg::CMD_RLCA) || (req.command == cpu8alu_pkg::CMD_RLA) ||
        (req.command == cpu8alu_pkg::CMD_RRCA) || (req.command == cpu8alu_pkg::CMD_RRA)) begin
      rsp.flags.zero = 1'b0;
    end
  end

endmodule

@@ hdl/cpu8_alu_with_flags_unit.sv @@
`timescale 1ns / 1ps
// Path: an accepted item passes the input register, then the result register, whose
// valid bit then marks the result as ready to be taken.
// Throughput: one item per cycle while the output is not stalled; the input register advances
// whenever the result register is empty or being emptied, so a stall only holds items in place.
// Reset: synchronous, active high; clears both valid bits, no payload is reset.
// ----------------------------------------------------------------------------
// cpu8_alu_with_flags_unit
// Two-stage ALU with zero, subtract, half carry and carry flags.
// ----------------------------------------------------------------------------
module cpu8_alu_with_flags_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  command,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [2:0]  bit_index,
  input  logic        zero_in,
  input  logic        subtract_in,
  input  logic        half_carry_in,
  input  logic        carry_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] result,
  output logic        zero_out,
  output logic        subtract_out,
  output logic        half_carry_out,
  output logic        carry_out
);

  logic                  req_valid;
  cpu8alu_pkg::alu_req_t req;
  cpu8alu_pkg::alu_rsp_t rsp_comb;
  logic                  rsp_valid;
  cpu8alu_pkg::alu_rsp_t rsp;
  logic                  rsp_load;
  logic                  req_advance;

  // Stage control: the result register takes a new item when empty or draining.
  assign rsp_load    = !rsp_valid || out_ready;
  assign req_advance = req_valid && rsp_load;
  assign in_ready    = !req_valid || rsp_load;

  // Input register valid and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= '{command: command, operand_a: operand_a, operand_b: operand_b,
               bit_index: bit_index,
               flags: '{zero: zero_in, subtract: subtract_in,
                        half_carry: half_carry_in, carry: carry_in}};
    end
  end

  cpu8alu_core u_core (
    .req (req),
    .rsp (rsp_comb)
  );

  // Result register valid and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_advance) begin
      rsp <= rsp_comb;
    end
  end

  assign out_valid      = rsp_valid;
  assign result         = rsp.result;
  assign zero_out       = rsp.flags.zero;
  assign subtract_out   = rsp.flags.subtract;
  assign half_carry_out = rsp.flags.half_carry;
  assign carry_out      = rsp.flags.carry;

endmodule

@@ hdl/cpu8alu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8alu_checker
// Port-level checks on flow through the ALU unit, bound to the top level.
// ----------------------------------------------------------------------------
module cpu8alu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [4:0]  command,
  input logic [15:0] operand_a,
  input logic [15:0] operand_b,
  input logic [2:0]  bit_index,
  input logic        zero_in,
  input logic        subtract_in,
  input logic        half_carry_in,
  input logic        carry_in,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] result,
  input logic        zero_out,
  input logic        subtract_out,
  input logic        half_carry_out,
  input logic        carry_out
);

  // A waiting input item keeps valid high and its payload unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid &&
      $stable({command, operand_a, operand_b, bit_index,
               zero_in, subtract_in, half_carry_in, carry_in}))
    else $error("waiting input item changed");

  // A stalled result item holds its value and flags.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({result, zero_out, subtract_out, half_carry_out, carry_out}))
    else $error("stalled result item changed");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // With the result register empty the unit must take an item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // An accepted item reaches the output, through the input and result registers, when the output keeps draining.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted item did not reach the output");

endmodule

bind cpu8_alu_with_flags_unit cpu8alu_checker u_checker (.*);
